// ===== design/sawq_pkg.sv =====
package sawq_pkg;

	localparam logic [1:0] KIND_REQUEST = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_DRAIN   = 2'd2;

	localparam logic REG_SLOT_COUNT = 1'b0;
	localparam logic REG_WAIT_EN    = 1'b1;

	localparam logic [6:0] SLOT_COUNT_RESET = 7'd64;
	localparam int         RESULT_LIMIT     = 64;

	typedef enum logic [2:0] {
		ST_GRANTED     = 3'd0,
		ST_QUEUED      = 3'd1,
		ST_TURNED_AWAY = 3'd2,
		ST_QUEUE_FULL  = 3'd3,
		ST_RELEASED    = 3'd4,
		ST_REJECTED    = 3'd5,
		ST_NOTHING     = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic room;
		logic more;
	} dp_sts_t;

endpackage

// ===== design/sawq_regs.sv =====
module sawq_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [6:0]  slot_count,
	output logic        wait_enabled
);

	logic [6:0] slot_count_q;
	logic       wait_q;
	logic       wr;

	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= sawq_pkg::SLOT_COUNT_RESET;
			wait_q       <= 1'b1;
		end else if (wr) begin
			unique case (paddr[2])
				sawq_pkg::REG_SLOT_COUNT: slot_count_q <= pwdata[6:0];
				sawq_pkg::REG_WAIT_EN:    wait_q       <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			sawq_pkg::REG_SLOT_COUNT: prdata = {25'd0, slot_count_q};
			sawq_pkg::REG_WAIT_EN:    prdata = {31'd0, wait_q};
		endcase
	end

	assign slot_count   = slot_count_q;
	assign wait_enabled = wait_q;

endmodule

// ===== design/sawq_ctrl.sv =====
module sawq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        kind,
	output logic              in_stall,
	input  sawq_pkg::dp_sts_t sts,
	output sawq_pkg::dp_cmd_t cmd
);

	sawq_pkg::state_t state_q;
	sawq_pkg::state_t state_d;
	logic             has_result;

	assign has_result = (kind == sawq_pkg::KIND_REQUEST) || (kind == sawq_pkg::KIND_RELEASE)
		|| (kind == sawq_pkg::KIND_DRAIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sawq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			sawq_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (has_result) begin
						state_d = sawq_pkg::S_EXEC;
					end
				end
			end
			sawq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sawq_pkg::S_EMIT;
			end
			sawq_pkg::S_EMIT: begin
				if (sts.room) begin
					cmd.emit = 1'b1;
					state_d  = sts.more ? sawq_pkg::S_EXEC : sawq_pkg::S_IDLE;
				end
			end
			default: state_d = sawq_pkg::S_IDLE;
		endcase
	end

endmodule

// ===== design/sawq_dp.sv =====
module sawq_dp #(
	parameter int SLOTS      = 64,
	parameter int WAIT_DEPTH = 64,
	parameter int ID_BITS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sawq_pkg::dp_cmd_t cmd,
	output sawq_pkg::dp_sts_t sts,
	input  logic [1:0]        kind,
	input  logic [15:0]       requester_id,
	input  logic [5:0]        slot_index,
	input  logic [31:0]       time_stamp,
	input  logic [6:0]        slot_count,
	input  logic              wait_enabled,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [2:0]        status,
	output logic [15:0]       requester_id_res,
	output logic [5:0]        slot_index_res,
	output logic [31:0]       time_stamp_res,
	output logic [6:0]        free_count,
	output logic [6:0]        waiting_count,
	output logic              last
);

	localparam int CAP = (SLOTS < 64) ? SLOTS : 64;
	localparam int SW  = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int NG  = (CAP + 7) / 8;
	localparam int PW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int CW  = $clog2(WAIT_DEPTH + 1);
	localparam int IW  = (ID_BITS < 16) ? ID_BITS : 16;
	localparam logic [15:0] ID_MASK = (ID_BITS >= 16) ? 16'hFFFF : 16'((1 << IW) - 1);

	logic [CAP-1:0]    occ_q;
	logic [PW-1:0]     head_q;
	logic [PW-1:0]     tail_q;
	logic [CW-1:0]     waiting_q;
	logic [6:0]        grant_cnt_q;
	logic              pend_dec_q;
	logic              pend_inc_q;
	logic              out_valid_q;

	logic [IW-1:0]     wait_mem [WAIT_DEPTH];
	logic [IW-1:0]     rd_q;

	logic [1:0]        kind_q;
	logic [15:0]       id_q;
	logic [5:0]        slot_q;
	logic [31:0]       ts_q;

	sawq_pkg::status_t pend_status_q;
	logic [15:0]       pend_id_q;
	logic [5:0]        pend_slot_q;
	logic [31:0]       pend_ts_q;

	sawq_pkg::status_t out_status_q;
	logic [15:0]       out_id_q;
	logic [5:0]        out_slot_q;
	logic [31:0]       out_ts_q;
	logic [6:0]        out_free_q;
	logic [6:0]        out_wait_q;
	logic              out_last_q;

	logic [6:0]        eff;
	logic [NG*8-1:0]   free_vec;
	logic [3:0]        grp_cnt_d [NG];
	logic [2:0]        grp_low_d [NG];
	logic [3:0]        grp_cnt_q [NG];
	logic [2:0]        grp_low_q [NG];
	logic [NG-1:0]     grp_any_q;
	logic              any_free;
	logic [5:0]        low_idx;
	logic [6:0]        free_sum;
	logic [6:0]        free_after;
	logic [15:0]       rd_id;
	logic [CW+6:0]     wait_ext;

	logic              rel_ok;
	logic              wait_full;
	logic              waiting_nz;
	logic              do_grant;
	logic              do_queue;
	logic              do_pop;
	logic              do_free;
	sawq_pkg::status_t p_status;
	logic [15:0]       p_id;
	logic [5:0]        p_slot;
	logic [31:0]       p_ts;
	logic              more;

	always_comb begin
		if (slot_count == 7'd0) begin
			eff = 7'd1;
		end else if (slot_count > 7'(CAP)) begin
			eff = 7'(CAP);
		end else begin
			eff = slot_count;
		end
	end

	for (genvar i = 0; i < NG * 8; i++) begin : g_free
		if (i < CAP) begin : g_slot
			assign free_vec[i] = !occ_q[i] && (7'(i) < eff);
		end else begin : g_pad
			assign free_vec[i] = 1'b0;
		end
	end

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_cnt_d[g] = 4'd0;
			grp_low_d[g] = 3'd0;
			for (int b = 7; b >= 0; b--) begin
				if (free_vec[g*8+b]) begin
					grp_low_d[g] = 3'(b);
				end
				grp_cnt_d[g] = grp_cnt_d[g] + {3'd0, free_vec[g*8+b]};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NG; g++) begin
			grp_cnt_q[g] <= grp_cnt_d[g];
			grp_low_q[g] <= grp_low_d[g];
			grp_any_q[g] <= |free_vec[g*8 +: 8];
		end
	end

	always_comb begin
		any_free = 1'b0;
		low_idx  = 6'd0;
		free_sum = 7'd0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				any_free = 1'b1;
				low_idx  = {3'(g), grp_low_q[g]};
			end
		end
		for (int g = 0; g < NG; g++) begin
			free_sum = free_sum + {3'd0, grp_cnt_q[g]};
		end
	end

	assign rd_id      = 16'({16'd0, rd_q});
	assign rel_ok     = ({1'b0, slot_q} < eff) && occ_q[slot_q[SW-1:0]];
	assign wait_full  = (waiting_q == CW'(WAIT_DEPTH));
	assign waiting_nz = (waiting_q != '0);

	always_comb begin
		do_grant = 1'b0;
		do_queue = 1'b0;
		do_pop   = 1'b0;
		do_free  = 1'b0;
		p_status = sawq_pkg::ST_NOTHING;
		p_id     = id_q;
		p_slot   = 6'd0;
		p_ts     = ts_q;
		unique case (kind_q)
			sawq_pkg::KIND_REQUEST: begin
				if (any_free) begin
					do_grant = 1'b1;
					p_status = sawq_pkg::ST_GRANTED;
					p_slot   = low_idx;
				end else if (!wait_enabled) begin
					p_status = sawq_pkg::ST_TURNED_AWAY;
				end else if (wait_full) begin
					p_status = sawq_pkg::ST_QUEUE_FULL;
				end else begin
					do_queue = 1'b1;
					p_status = sawq_pkg::ST_QUEUED;
				end
			end
			sawq_pkg::KIND_RELEASE: begin
				p_slot = slot_q;
				p_ts   = 32'd0;
				if (rel_ok) begin
					do_free  = 1'b1;
					p_status = sawq_pkg::ST_RELEASED;
				end else begin
					p_status = sawq_pkg::ST_REJECTED;
				end
			end
			sawq_pkg::KIND_DRAIN: begin
				if (waiting_nz && any_free) begin
					do_grant = 1'b1;
					do_pop   = 1'b1;
					p_status = sawq_pkg::ST_GRANTED;
					p_id     = rd_id;
					p_slot   = low_idx;
				end else begin
					p_id = 16'd0;
				end
			end
			default: begin
				p_id = 16'd0;
			end
		endcase
	end

	assign free_after = free_sum - {6'd0, pend_dec_q} + {6'd0, pend_inc_q};
	assign more = (kind_q == sawq_pkg::KIND_DRAIN) && (pend_status_q == sawq_pkg::ST_GRANTED)
		&& waiting_nz && (free_after != 7'd0) && (grant_cnt_q != 7'(sawq_pkg::RESULT_LIMIT));
	assign wait_ext = {7'd0, waiting_q};

	assign sts.room = !out_valid_q || !out_stall;
	assign sts.more = more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			waiting_q   <= '0;
			grant_cnt_q <= 7'd0;
			pend_dec_q  <= 1'b0;
			pend_inc_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_dec_q <= cmd.exec && do_grant;
			pend_inc_q <= cmd.exec && do_free;
			if (cmd.load) begin
				grant_cnt_q <= 7'd0;
			end
			if (cmd.exec) begin
				if (do_grant) begin
					occ_q[low_idx[SW-1:0]] <= 1'b1;
					grant_cnt_q            <= grant_cnt_q + 7'd1;
				end
				if (do_free) begin
					occ_q[slot_q[SW-1:0]] <= 1'b0;
				end
				if (do_queue) begin
					tail_q    <= (tail_q == PW'(WAIT_DEPTH - 1)) ? '0 : tail_q + 1'b1;
					waiting_q <= waiting_q + 1'b1;
				end
				if (do_pop) begin
					head_q    <= (head_q == PW'(WAIT_DEPTH - 1)) ? '0 : head_q + 1'b1;
					waiting_q <= waiting_q - 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= wait_mem[head_q];
		if (cmd.exec && do_queue) begin
			wait_mem[tail_q] <= id_q[IW-1:0];
		end
		if (cmd.load) begin
			kind_q <= kind;
			id_q   <= requester_id & ID_MASK;
			slot_q <= slot_index;
			ts_q   <= time_stamp;
		end
		if (cmd.exec) begin
			pend_status_q <= p_status;
			pend_id_q     <= p_id;
			pend_slot_q   <= p_slot;
			pend_ts_q     <= p_ts;
		end
		if (cmd.emit) begin
			out_status_q <= pend_status_q;
			out_id_q     <= pend_id_q;
			out_slot_q   <= pend_slot_q;
			out_ts_q     <= pend_ts_q;
			out_free_q   <= free_after;
			out_wait_q   <= wait_ext[6:0];
			out_last_q   <= !more;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign requester_id_res = out_id_q;
	assign slot_index_res   = out_slot_q;
	assign time_stamp_res   = out_ts_q;
	assign free_count       = out_free_q;
	assign waiting_count    = out_wait_q;
	assign last             = out_last_q;

endmodule

// ===== design/slot_allocator_with_wait_queue_top.sv =====
// First-fit slot allocator with a bounded FIFO wait queue. A request takes the lowest free
// slot below the configured slot count, or is queued (or turned away when waiting is off or
// the queue is full); a release frees an occupied slot; a drain hands free slots to queued
// requesters in arrival order, one result per grant, up to 64 grants per request, with last
// set on the final result; a drain that can grant nothing gives a single result. The
// controller loads an accepted operation, then runs its execute and emit steps, repeating
// them for each result of a drain; the execute step reads a first-free search and free count
// registered from the occupancy map. Results wait in an output register, and a stalled
// output holds the emit step. Configuration is written through the APB port at byte
// address 0 (slot_count) and 4 (wait_enabled).
module slot_allocator_with_wait_queue_top #(
	parameter int SLOTS      = 64,
	parameter int WAIT_DEPTH = 64,
	parameter int ID_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] requester_id,
	input  logic [5:0]  slot_index,
	input  logic [31:0] time_stamp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] requester_id_res,
	output logic [5:0]  slot_index_res,
	output logic [31:0] time_stamp_res,
	output logic [6:0]  free_count,
	output logic [6:0]  waiting_count,
	output logic        last
);

	logic [6:0]        slot_count;
	logic              wait_enabled;
	sawq_pkg::dp_cmd_t cmd;
	sawq_pkg::dp_sts_t sts;

	sawq_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.slot_count   (slot_count),
		.wait_enabled (wait_enabled)
	);

	sawq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sawq_dp #(
		.SLOTS      (SLOTS),
		.WAIT_DEPTH (WAIT_DEPTH),
		.ID_BITS    (ID_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.kind             (kind),
		.requester_id     (requester_id),
		.slot_index       (slot_index),
		.time_stamp       (time_stamp),
		.slot_count       (slot_count),
		.wait_enabled     (wait_enabled),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.status           (status),
		.requester_id_res (requester_id_res),
		.slot_index_res   (slot_index_res),
		.time_stamp_res   (time_stamp_res),
		.free_count       (free_count),
		.waiting_count    (waiting_count),
		.last             (last)
	);

endmodule

// ===== design/sawq_checker.sv =====
module sawq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  kind,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [5:0]  slot_index_res,
	input logic [31:0] time_stamp_res,
	input logic        last
);

	a_more_only_grants: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == sawq_pkg::ST_GRANTED)
		else $error("non-final result is not a grant");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == sawq_pkg::KIND_REQUEST
			|| kind == sawq_pkg::KIND_RELEASE || kind == sawq_pkg::KIND_DRAIN)
		|=> in_stall)
		else $error("request taken while previous one still in progress");

	a_no_slot_when_not_granted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sawq_pkg::ST_QUEUED || status == sawq_pkg::ST_TURNED_AWAY
			|| status == sawq_pkg::ST_QUEUE_FULL || status == sawq_pkg::ST_NOTHING)
		|-> slot_index_res == 6'd0)
		else $error("slot reported on a result without a slot");

	a_release_no_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sawq_pkg::ST_RELEASED || status == sawq_pkg::ST_REJECTED)
		|-> time_stamp_res == 32'd0 && last)
		else $error("release result with time stamp or not final");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(last))
		else $error("stalled result changed");

endmodule

bind slot_allocator_with_wait_queue_top sawq_checker u_sawq_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam logic [1:0] KIND_UNUSED     = 2'd3;
	localparam logic [2:0] ADDR_SLOT_COUNT = {sawq_pkg::REG_SLOT_COUNT, 2'b00};
	localparam logic [2:0] ADDR_WAIT_EN    = {sawq_pkg::REG_WAIT_EN, 2'b00};
	localparam int         POOL_MAX        = 64;
	localparam int         QUEUE_DEPTH     = 64;
	localparam int         SETTLE_CYCLES   = 10;
	localparam int         SQUEEZE_CYCLES  = 300;
	localparam int         REQUEST_TARGET  = 430;

	typedef struct packed {
		sawq_pkg::status_t st;
		logic [15:0] id;
		logic [5:0]  slot;
		logic [31:0] ts;
		logic [6:0]  nfree;
		logic [6:0]  nwait;
		logic        fin;
	} outcome_t;

	typedef struct {
		logic        is_cfg;
		logic [2:0]  addr;
		logic [31:0] wdata;
		logic [1:0]  kind;
		logic [15:0] id;
		logic [5:0]  slot;
		logic [31:0] ts;
		logic        typed;
		outcome_t    want;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = sawq_pkg::KIND_REQUEST;
	logic [15:0] requester_id = '0;
	logic [5:0]  slot_index = '0;
	logic [31:0] time_stamp = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [2:0]  status;
	logic [15:0] requester_id_res;
	logic [5:0]  slot_index_res;
	logic [31:0] time_stamp_res;
	logic [6:0]  free_count;
	logic [6:0]  waiting_count;
	logic        last;

	// pool model
	logic [63:0] taken = '0;
	logic [15:0] waitq [QUEUE_DEPTH];
	logic [5:0]  wq_head = '0;
	logic [5:0]  wq_tail = '0;
	logic [6:0]  wq_count = '0;
	logic [6:0]  pool_reg = sawq_pkg::SLOT_COUNT_RESET;
	logic        wait_reg = 1'b1;
	outcome_t    expected_outcomes [$];

	logic        pin_typed = 1'b0;
	outcome_t    pin_want = '0;
	logic        calm = 1'b0;
	logic        squeeze = 1'b0;
	int          errors = 0;
	int          reported = 0;
	int          results_checked = 0;
	int          requests_sent = 0;
	int          settings = 0;

	slot_allocator_with_wait_queue_top u_dut (.*);

	always #5 clk = ~clk;

	function automatic int pool_size();
		int e;
		e = pool_reg;
		if (e < 1) e = 1;
		if (e > POOL_MAX) e = POOL_MAX;
		return e;
	endfunction

	function automatic int free_slots();
		int n, i;
		n = 0;
		for (i = 0; i < pool_size(); i++)
			if (!taken[i]) n++;
		return n;
	endfunction

	function automatic int first_free();
		int i;
		for (i = 0; i < pool_size(); i++)
			if (!taken[i]) return i;
		return -1;
	endfunction

	function automatic outcome_t outcome(sawq_pkg::status_t st, logic [15:0] id,
			logic [5:0] slot, logic [31:0] ts);
		outcome_t o;
		o.st = st;
		o.id = id;
		o.slot = slot;
		o.ts = ts;
		o.nfree = 7'(free_slots());
		o.nwait = wq_count;
		o.fin = 1'b0;
		return o;
	endfunction

	task automatic predict_allocation(logic [1:0] k, logic [15:0] id, logic [5:0] slot,
			logic [31:0] ts);
		outcome_t batch [$];
		int s;
		case (k)
			sawq_pkg::KIND_REQUEST: begin
				s = first_free();
				if (s >= 0) begin
					taken[s] = 1'b1;
					batch.push_back(outcome(sawq_pkg::ST_GRANTED, id, 6'(s), ts));
				end else if (!wait_reg) begin
					batch.push_back(outcome(sawq_pkg::ST_TURNED_AWAY, id, '0, ts));
				end else if (wq_count >= QUEUE_DEPTH) begin
					batch.push_back(outcome(sawq_pkg::ST_QUEUE_FULL, id, '0, ts));
				end else begin
					waitq[wq_tail] = id;
					wq_tail++;
					wq_count++;
					batch.push_back(outcome(sawq_pkg::ST_QUEUED, id, '0, ts));
				end
			end
			sawq_pkg::KIND_RELEASE: begin
				if (slot < pool_size() && taken[slot]) begin
					taken[slot] = 1'b0;
					batch.push_back(outcome(sawq_pkg::ST_RELEASED, id, slot, '0));
				end else begin
					batch.push_back(outcome(sawq_pkg::ST_REJECTED, id, slot, '0));
				end
			end
			sawq_pkg::KIND_DRAIN: begin
				s = first_free();
				while (wq_count > 0 && batch.size() < sawq_pkg::RESULT_LIMIT && s >= 0)
				begin
					taken[s] = 1'b1;
					wq_count--;
					batch.push_back(outcome(sawq_pkg::ST_GRANTED, waitq[wq_head], 6'(s), ts));
					wq_head++;
					s = first_free();
				end
				if (batch.size() == 0)
					batch.push_back(outcome(sawq_pkg::ST_NOTHING, '0, '0, ts));
			end
			default: ;
		endcase
		if (batch.size() > 0) begin
			batch[$].fin = 1'b1;
			foreach (batch[i])
				expected_outcomes.push_back(batch[i]);
		end
	endtask

	always @(posedge clk) begin
		outcome_t got, want;
		int mark;
		if (arst_n) begin
			if (in_valid && in_stall === 1'b0) begin
				mark = expected_outcomes.size();
				predict_allocation(kind, requester_id, slot_index, time_stamp);
				if (pin_typed && expected_outcomes.size() == mark + 1)
					expected_outcomes[mark] = pin_want;
			end
			if (out_valid === 1'b1 && !out_stall) begin
				got.st = sawq_pkg::status_t'(status);
				got.id = requester_id_res;
				got.slot = slot_index_res;
				got.ts = time_stamp_res;
				got.nfree = free_count;
				got.nwait = waiting_count;
				got.fin = last;
				if (expected_outcomes.size() == 0) begin
					errors++;
					if (reported < 10) begin
						reported++;
						$display("%0t: unexpected result st=%0d id=%h slot=%0d ts=%h",
							$time, got.st, got.id, got.slot, got.ts);
					end
				end else begin
					want = expected_outcomes.pop_front();
					results_checked++;
					if (got !== want) begin
						errors++;
						if (reported < 10) begin
							reported++;
							$display("%0t: mismatch exp st=%0d id=%h slot=%0d ts=%h free=%0d wait=%0d last=%b",
								$time, want.st, want.id, want.slot, want.ts,
								want.nfree, want.nwait, want.fin);
							$display("%0t:          got st=%0d id=%h slot=%0d ts=%h free=%0d wait=%0d last=%b",
								$time, got.st, got.id, got.slot, got.ts,
								got.nfree, got.nwait, got.fin);
						end
					end
				end
			end
		end
	end

	task automatic offer(logic [1:0] k, logic [15:0] id, logic [5:0] slot, logic [31:0] ts,
			logic typed, outcome_t want);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		requester_id <= id;
		slot_index <= slot;
		time_stamp <= ts;
		pin_typed <= typed;
		pin_want <= want;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
		if (k != KIND_UNUSED) requests_sent++;
	endtask

	task automatic settle(int tail);
		in_valid <= 1'b0;
		while (expected_outcomes.size() != 0) @(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_SLOT_COUNT) pool_reg = data[6:0];
		else wait_reg = data[0];
		@(negedge clk);
	endtask

	task automatic set_pool(logic [6:0] slots, logic wait_on);
		settle(SETTLE_CYCLES);
		write_reg(ADDR_SLOT_COUNT, 32'(slots));
		write_reg(ADDR_WAIT_EN, 32'(wait_on));
		settings++;
	endtask

	function automatic step_t plain_row(logic [1:0] k, logic [15:0] id, logic [5:0] slot,
			logic [31:0] ts);
		step_t r;
		r.is_cfg = 1'b0;
		r.addr = '0;
		r.wdata = '0;
		r.kind = k;
		r.id = id;
		r.slot = slot;
		r.ts = ts;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic step_t checked_row(logic [1:0] k, logic [15:0] id, logic [5:0] slot,
			logic [31:0] ts, sawq_pkg::status_t st, logic [15:0] rid, logic [5:0] rslot,
			logic [31:0] rts, logic [6:0] nfree, logic [6:0] nwait);
		step_t r;
		r = plain_row(k, id, slot, ts);
		r.typed = 1'b1;
		r.want.st = st;
		r.want.id = rid;
		r.want.slot = rslot;
		r.want.ts = rts;
		r.want.nfree = nfree;
		r.want.nwait = nwait;
		r.want.fin = 1'b1;
		return r;
	endfunction

	function automatic step_t reg_row(logic [2:0] addr, logic [31:0] data);
		step_t r;
		r = plain_row(KIND_UNUSED, '0, '0, '0);
		r.is_cfg = 1'b1;
		r.addr = addr;
		r.wdata = data;
		return r;
	endfunction

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int hold;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 13);
			if (squeeze) begin
				hold = SQUEEZE_CYCLES;
				squeeze = 1'b0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	initial begin
		step_t plan [$];
		int phase, len, req_pct, r, s, i, j;
		int picks [$];
		logic [6:0] slots;
		logic [1:0] k;
		logic [5:0] pick;

		plan.push_back(checked_row(sawq_pkg::KIND_DRAIN, 16'hFFFF, 6'd63, 32'hFFFF_FFFF,
			sawq_pkg::ST_NOTHING, 16'h0000, 6'd0, 32'hFFFF_FFFF, 7'd64, 7'd0));
		plan.push_back(plain_row(KIND_UNUSED, 16'hA5A5, 6'd21, 32'h5A5A_5A5A));
		plan.push_back(checked_row(sawq_pkg::KIND_REQUEST, 16'h0000, 6'd63, 32'h0000_0000,
			sawq_pkg::ST_GRANTED, 16'h0000, 6'd0, 32'h0000_0000, 7'd63, 7'd0));
		plan.push_back(checked_row(sawq_pkg::KIND_REQUEST, 16'hFFFF, 6'd0, 32'hFFFF_FFFF,
			sawq_pkg::ST_GRANTED, 16'hFFFF, 6'd1, 32'hFFFF_FFFF, 7'd62, 7'd0));
		plan.push_back(checked_row(sawq_pkg::KIND_RELEASE, 16'h0042, 6'd63, 32'h1234_5678,
			sawq_pkg::ST_REJECTED, 16'h0042, 6'd63, 32'h0, 7'd62, 7'd0));
		plan.push_back(checked_row(sawq_pkg::KIND_RELEASE, 16'h0042, 6'd0, 32'h1234_5679,
			sawq_pkg::ST_RELEASED, 16'h0042, 6'd0, 32'h0, 7'd63, 7'd0));
		plan.push_back(checked_row(sawq_pkg::KIND_REQUEST, 16'h0101, 6'd33, 32'h10,
			sawq_pkg::ST_GRANTED, 16'h0101, 6'd0, 32'h10, 7'd62, 7'd0));
		plan.push_back(reg_row(ADDR_SLOT_COUNT, 32'd2));
		plan.push_back(checked_row(sawq_pkg::KIND_REQUEST, 16'h1234, 6'd0, 32'h20,
			sawq_pkg::ST_QUEUED, 16'h1234, 6'd0, 32'h20, 7'd0, 7'd1));
		plan.push_back(checked_row(sawq_pkg::KIND_REQUEST, 16'h5678, 6'd0, 32'h21,
			sawq_pkg::ST_QUEUED, 16'h5678, 6'd0, 32'h21, 7'd0, 7'd2));
		plan.push_back(checked_row(sawq_pkg::KIND_RELEASE, 16'h0101, 6'd1, 32'h22,
			sawq_pkg::ST_RELEASED, 16'h0101, 6'd1, 32'h0, 7'd1, 7'd2));
		plan.push_back(checked_row(sawq_pkg::KIND_REQUEST, 16'h9ABC, 6'd0, 32'h23,
			sawq_pkg::ST_GRANTED, 16'h9ABC, 6'd1, 32'h23, 7'd0, 7'd2));
		plan.push_back(reg_row(ADDR_WAIT_EN, 32'd0));
		plan.push_back(checked_row(sawq_pkg::KIND_REQUEST, 16'hDEAD, 6'd0, 32'h24,
			sawq_pkg::ST_TURNED_AWAY, 16'hDEAD, 6'd0, 32'h24, 7'd0, 7'd2));
		plan.push_back(checked_row(sawq_pkg::KIND_RELEASE, 16'h0000, 6'd0, 32'h25,
			sawq_pkg::ST_RELEASED, 16'h0000, 6'd0, 32'h0, 7'd1, 7'd2));
		plan.push_back(plain_row(sawq_pkg::KIND_DRAIN, 16'h0000, 6'd0, 32'h26));
		plan.push_back(reg_row(ADDR_SLOT_COUNT, 32'd0));
		plan.push_back(checked_row(sawq_pkg::KIND_RELEASE, 16'hBEEF, 6'd1, 32'h27,
			sawq_pkg::ST_REJECTED, 16'hBEEF, 6'd1, 32'h0, 7'd0, 7'd1));
		plan.push_back(checked_row(sawq_pkg::KIND_RELEASE, 16'hBEEF, 6'd0, 32'h28,
			sawq_pkg::ST_RELEASED, 16'hBEEF, 6'd0, 32'h0, 7'd1, 7'd1));
		plan.push_back(reg_row(ADDR_WAIT_EN, 32'd1));
		plan.push_back(reg_row(ADDR_SLOT_COUNT, 32'd127));
		plan.push_back(plain_row(sawq_pkg::KIND_DRAIN, 16'h7777, 6'd0, 32'h29));
		plan.push_back(checked_row(sawq_pkg::KIND_DRAIN, 16'h7777, 6'd5, 32'h2A,
			sawq_pkg::ST_NOTHING, 16'h0000, 6'd0, 32'h2A, 7'd62, 7'd0));
		plan.push_back(checked_row(sawq_pkg::KIND_RELEASE, 16'h0001, 6'd1, 32'h2B,
			sawq_pkg::ST_RELEASED, 16'h0001, 6'd1, 32'h0, 7'd63, 7'd0));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[n]) begin
			if (plan[n].is_cfg) begin
				settle(SETTLE_CYCLES);
				write_reg(plan[n].addr, plan[n].wdata);
			end else begin
				offer(plan[n].kind, plan[n].id, plan[n].slot, plan[n].ts,
					plan[n].typed, plan[n].want);
			end
		end

		phase = 0;
		while (requests_sent < REQUEST_TARGET) begin
			phase++;
			calm = (phase == 2) || ($urandom_range(0, 3) == 0);
			if (phase == 3) begin
				// empty the pool and the queue, then queue a full depth behind one slot
				set_pool(7'd127, 1'b1);
				while (wq_count != 0 || taken != '0) begin
					if (wq_count != 0 && free_slots() != 0) begin
						offer(sawq_pkg::KIND_DRAIN, 16'($urandom), 6'($urandom), $urandom,
							1'b0, '0);
					end else begin
						s = 0;
						for (i = POOL_MAX - 1; i >= 0; i--)
							if (taken[i]) s = i;
						offer(sawq_pkg::KIND_RELEASE, 16'($urandom), 6'(s), $urandom,
							1'b0, '0);
					end
				end
				set_pool(7'd1, 1'b1);
				repeat (QUEUE_DEPTH + 2)
					offer(sawq_pkg::KIND_REQUEST, 16'($urandom), 6'($urandom), $urandom,
						1'b0, '0);
				set_pool(sawq_pkg::SLOT_COUNT_RESET, 1'b1);
				offer(sawq_pkg::KIND_RELEASE, 16'($urandom), 6'd0, $urandom, 1'b0, '0);
				offer(sawq_pkg::KIND_DRAIN, 16'($urandom), 6'($urandom), $urandom, 1'b0, '0);
				offer(sawq_pkg::KIND_DRAIN, 16'($urandom), 6'($urandom), $urandom, 1'b0, '0);
			end else begin
				case ($urandom_range(0, 5))
					0: slots = 7'($urandom_range(1, 4));
					1: slots = 7'($urandom_range(0, 127));
					2: slots = sawq_pkg::SLOT_COUNT_RESET;
					3: slots = 7'd127;
					4: slots = 7'd0;
					default: slots = 7'($urandom_range(1, 64));
				endcase
				set_pool(slots, $urandom_range(0, 3) != 0);
				req_pct = $urandom_range(35, 70);
				len = $urandom_range(25, 45);
				for (j = 0; j < len; j++) begin
					if (phase == 2 && j == 5) squeeze = 1'b1;
					if (phase == 4 && j == len / 2) settle(1);
					r = $urandom_range(0, 99);
					if (r < 4) k = KIND_UNUSED;
					else if (r < 4 + req_pct) k = sawq_pkg::KIND_REQUEST;
					else if (r < 4 + req_pct + (96 - req_pct) * 6 / 10)
						k = sawq_pkg::KIND_RELEASE;
					else k = sawq_pkg::KIND_DRAIN;
					pick = 6'($urandom_range(0, 63));
					if (k == sawq_pkg::KIND_RELEASE && $urandom_range(0, 3) != 0) begin
						picks.delete();
						for (i = 0; i < pool_size(); i++)
							if (taken[i]) picks.push_back(i);
						if (picks.size() > 0)
							pick = 6'(picks[$urandom_range(0, picks.size() - 1)]);
					end
					offer(k, 16'($urandom), pick, $urandom, 1'b0, '0);
				end
			end
		end

		settle(SETTLE_CYCLES);
		$display("Run covered %0d requests over %0d pool settings, %0d results checked,",
			requests_sent, settings, results_checked);
		$display("including queue overflow and a full 64-grant drain; %0d failures.", errors);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== slot_allocator_with_wait_queue_top.f =====
design/sawq_pkg.sv
design/sawq_regs.sv
design/sawq_ctrl.sv
design/sawq_dp.sv
design/slot_allocator_with_wait_queue_top.sv
design/sawq_checker.sv
tb/tb.sv
